// ===== rtl/suim_pkg.sv =====
// ----------------------------------------------------------------------------
// suim_pkg: shared types and constants for the sort/unique id map
// Sizes of the id store, the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package suim_pkg;
  localparam int unsigned MaxIds  = 64;
  localparam int unsigned PidW    = 64;
  localparam int unsigned IdxW    = (MaxIds > 1) ? $clog2(MaxIds) : 1;
  localparam int unsigned CntW    = $clog2(MaxIds + 1);
  localparam int unsigned MapW    = 6;

  // controller -> datapath
  typedef struct packed {
    logic store_wr;   // write incoming pid at fill count
    logic drop;       // set overflow flag
    logic clr_set;    // clear count and overflow flag
    logic sort_start; // load outer index i=1
    logic rd_key;     // issue read of key at i
    logic rd_prev;    // issue read at j-1
    logic shift_wr;   // store[j] <= store[j-1], j--
    logic key_wr;     // store[j] <= key, i++
    logic max_rd;     // issue read of greatest id at count-1
    logic max_load;   // capture greatest id
    logic out_start;  // emit pointer to 0
    logic out_rd;     // issue read at emit pointer
    logic out_load;   // evaluate read data into output register
  } suim_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;       // fill count at capacity
    logic sort_done;  // i >= count
    logic j_zero;     // j == 0
    logic prev_gt;    // store[j-1] > key
    logic out_done;   // emit pointer reached count
    logic out_busy;   // output register holds a beat
  } suim_sts_t;
endpackage
`default_nettype wire

// ===== rtl/sort_unique_id_map.sv =====
// ----------------------------------------------------------------------------
// sort_unique_id_map: sorted, de-duplicated dense id map
// Loads up to MaxIds ids, insertion-sorts them in place, drains distinct ids.
// ----------------------------------------------------------------------------
// Load: one beat per cycle; ids beyond capacity are dropped and flag overflow.
// Sort: insertion sort over the single-port store; then the greatest id is
//   fetched from the store for the last-result flag.
// Drain: each stored id is read through the store read port, and each result
//   beat waits for its handshake; input is ready again after the last result
//   beat is taken.
// Reset (rst_ni low, async) empties the set; store contents are not cleared.
`default_nettype none
module sort_unique_id_map (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] pid
  input  wire logic        s_axis_tlast,   // last_id
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [63:0] unique_pid, [69:64] map_index,
                                           // [70] overflow, [71] zero pad
  output logic             m_axis_tlast    // last_result
);
  suim_pkg::suim_cmd_t cmd;
  suim_pkg::suim_sts_t sts;
  logic in_fire;
  logic [63:0] opid;
  logic [5:0] oidx;
  logic ovf;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  suim_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i (in_fire),
    .in_last_i (s_axis_tlast),
    .sts_i     (sts),
    .in_ready_o(s_axis_tready),
    .cmd_o     (cmd)
  );

  suim_dp u_dp (
    .clk_i, .rst_ni,
    .pid_i      (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_pid_o  (opid),
    .out_idx_o  (oidx),
    .out_last_o (m_axis_tlast),
    .out_ovf_o  (ovf)
  );

  assign m_axis_tdata = {1'b0, ovf, oidx, opid};

  // no input taken while results drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted during drain");
  // store write and drop never together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.store_wr && cmd.drop))
    else $error("write and drop together");
  // a waiting result beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result beat changed while waiting");
endmodule
`default_nettype wire

// ===== rtl/suim_ctrl.sv =====
// ----------------------------------------------------------------------------
// suim_ctrl: sequencer for load, insertion sort and unique drain
// Walks the sort one memory access per cycle and paces the drain.
// ----------------------------------------------------------------------------
`default_nettype none
module suim_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_fire_i,
  input  wire logic               in_last_i,
  input  wire suim_pkg::suim_sts_t sts_i,
  output logic                    in_ready_o,
  output suim_pkg::suim_cmd_t     cmd_o
);
  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StOuter = 3'd1;
  localparam logic [2:0] StKey   = 3'd2;
  localparam logic [2:0] StInner = 3'd3;
  localparam logic [2:0] StCmp   = 3'd4;
  localparam logic [2:0] StDrain = 3'd5;
  localparam logic [2:0] StEval  = 3'd6;
  localparam logic [2:0] StMax   = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StLoad;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.store_wr = !sts_i.full;
          cmd_o.drop     = sts_i.full;
          if (in_last_i) begin
            cmd_o.sort_start = 1'b1;
            state_d          = StOuter;
          end
        end
      end
      StOuter: begin
        if (sts_i.sort_done) begin
          cmd_o.max_rd = 1'b1;
          state_d      = StMax;
        end else begin
          cmd_o.rd_key = 1'b1;
          state_d      = StKey;
        end
      end
      StKey: begin  // key captured, j = i
        cmd_o.rd_prev = 1'b1;
        state_d       = StCmp;
      end
      StCmp: begin  // prev data valid
        if (!sts_i.j_zero && sts_i.prev_gt) begin
          cmd_o.shift_wr = 1'b1;
          state_d        = StInner;
        end else begin
          cmd_o.key_wr = 1'b1;
          state_d      = StOuter;
        end
      end
      StInner: begin
        if (sts_i.j_zero) begin
          cmd_o.key_wr = 1'b1;
          state_d      = StOuter;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = StCmp;
        end
      end
      StMax: begin  // greatest id on read data
        cmd_o.max_load  = 1'b1;
        cmd_o.out_start = 1'b1;
        state_d         = StDrain;
      end
      StDrain: begin
        if (sts_i.out_done) begin
          if (!sts_i.out_busy) begin
            cmd_o.clr_set = 1'b1;
            state_d       = StLoad;
          end
        end else if (!sts_i.out_busy) begin
          cmd_o.out_rd = 1'b1;
          state_d      = StEval;
        end
      end
      StEval: begin
        cmd_o.out_load = 1'b1;
        state_d        = StDrain;
      end
      default: state_d = StLoad;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/suim_dp.sv =====
// ----------------------------------------------------------------------------
// suim_dp: id store, sort indices and output register
// Single-port store with registered read; one access per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module suim_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [suim_pkg::PidW-1:0]  pid_i,
  input  wire suim_pkg::suim_cmd_t        cmd_i,
  output suim_pkg::suim_sts_t             sts_o,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic [suim_pkg::PidW-1:0]       out_pid_o,
  output logic [suim_pkg::MapW-1:0]       out_idx_o,
  output logic                            out_last_o,
  output logic                            out_ovf_o
);
  localparam int unsigned IW = suim_pkg::IdxW;
  localparam int unsigned CW = suim_pkg::CntW;

  logic [suim_pkg::PidW-1:0] mem [suim_pkg::MaxIds];
  logic [suim_pkg::PidW-1:0] rdata_q, key_q, prev_q, max_q;
  logic [CW-1:0] cnt_q, i_q, j_q, ptr_q;
  logic [suim_pkg::MapW-1:0] k_q;
  logic ovf_q, have_prev_q, key_pend_q, vld_q, last_q;
  logic [suim_pkg::PidW-1:0] opid_q;
  logic [suim_pkg::MapW-1:0] oidx_q;
  logic oovf_q;

  logic mem_we;
  logic [IW-1:0] waddr, raddr;
  logic [suim_pkg::PidW-1:0] wdata;
  logic [CW-1:0] jm1, cntm1;
  logic is_dup;

  assign jm1   = j_q - CW'(1);
  assign cntm1 = cnt_q - CW'(1);

  always_comb begin
    mem_we = 1'b0;
    waddr  = cnt_q[IW-1:0];
    wdata  = pid_i;
    priority if (cmd_i.store_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.shift_wr) begin
      mem_we = 1'b1;
      waddr  = j_q[IW-1:0];
      wdata  = rdata_q;
    end else if (cmd_i.key_wr) begin
      mem_we = 1'b1;
      waddr  = j_q[IW-1:0];
      wdata  = key_q;
    end else begin
      mem_we = 1'b0;
    end
    priority if (cmd_i.rd_prev) raddr = jm1[IW-1:0];
    else if (cmd_i.out_rd)      raddr = ptr_q[IW-1:0];
    else if (cmd_i.max_rd)      raddr = cntm1[IW-1:0];
    else                        raddr = i_q[IW-1:0];
  end

  // store, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // key captured the cycle after its read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pend_q <= 1'b0;
    end else begin
      key_pend_q <= cmd_i.rd_key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_pend_q)     key_q  <= rdata_q;
    if (cmd_i.max_load) max_q  <= rdata_q;
    if (cmd_i.out_load) prev_q <= rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      i_q   <= '0;
      j_q   <= '0;
      ptr_q <= '0;
      k_q   <= '0;
      have_prev_q <= 1'b0;
    end else begin
      if (cmd_i.store_wr) cnt_q <= cnt_q + CW'(1);
      if (cmd_i.drop)     ovf_q <= 1'b1;
      if (cmd_i.clr_set) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      if (cmd_i.sort_start) i_q <= CW'(1);
      if (cmd_i.rd_key)     j_q <= i_q;
      if (cmd_i.shift_wr)   j_q <= jm1;
      if (cmd_i.key_wr)     i_q <= i_q + CW'(1);
      if (cmd_i.out_start) begin
        ptr_q       <= '0;
        k_q         <= '0;
        have_prev_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        ptr_q       <= ptr_q + CW'(1);
        have_prev_q <= 1'b1;
        if (!is_dup) k_q <= k_q + suim_pkg::MapW'(1);
      end
    end
  end

  // sorted order: an entry equal to its predecessor is skipped
  assign is_dup = have_prev_q && (rdata_q == prev_q);

  // output register; drain waits until it is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (vld_q && out_ready_i) begin
      vld_q <= 1'b0;
    end else if (cmd_i.out_load && !is_dup) begin
      vld_q <= 1'b1;
    end
  end

  // the first copy of the greatest id closes the run
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load && !is_dup) begin
      opid_q <= rdata_q;
      oidx_q <= k_q;
      last_q <= (rdata_q == max_q);
      oovf_q <= ovf_q;
    end
  end

  assign out_valid_o = vld_q;
  assign out_pid_o   = opid_q;
  assign out_idx_o   = oidx_q;
  assign out_last_o  = last_q;
  assign out_ovf_o   = oovf_q;

  assign sts_o.full      = (cnt_q == CW'(suim_pkg::MaxIds));
  assign sts_o.sort_done = (i_q >= cnt_q);
  assign sts_o.j_zero    = (j_q == '0);
  assign sts_o.prev_gt   = (rdata_q > key_q);
  assign sts_o.out_done  = (ptr_q == cnt_q);
  assign sts_o.out_busy  = vld_q;
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sort_unique_id_map
// Streams sets of ids into the block and checks every result beat against a
// behavioral predictor (store, sort, de-duplicate, dense index, overflow).
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] pid;
    logic [5:0]  idx;
    logic        lst;
    logic        ovf;
  } map_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [63:0] pid
  logic        s_axis_tlast;   // last_id
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // [63:0] unique_pid, [69:64] map_index, [70] overflow
  logic        m_axis_tlast;   // last_result

  sort_unique_id_map u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // predictor state
  logic [63:0] id_set[suim_pkg::MaxIds];
  int          id_count;
  bit          id_dropped;
  map_beat_t   map_expected[$];
  int          errors;
  bit          hold_off;     // long receiver stall request
  bit          rx_free_run;  // receiver never idles

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Add one accepted id; on a marked beat produce the sorted distinct map.
  task automatic predict_id(input logic [63:0] pid, input logic lst);
    logic [63:0] key;
    int j;
    int k;
    map_beat_t b;
    if (id_count < suim_pkg::MaxIds) begin
      id_set[id_count] = pid;
      id_count++;
    end else begin
      id_dropped = 1'b1;
    end
    if (!lst) return;
    for (int i = 1; i < id_count; i++) begin
      key = id_set[i];
      j = i;
      while (j > 0 && id_set[j-1] > key) begin
        id_set[j] = id_set[j-1];
        j--;
      end
      id_set[j] = key;
    end
    k = 0;
    for (int i = 0; i < id_count; i++) begin
      if (i > 0 && id_set[i] == id_set[i-1]) continue;
      b.pid = id_set[i];
      b.idx = k[5:0];
      b.lst = 1'b0;
      b.ovf = id_dropped;
      map_expected.push_back(b);
      k++;
    end
    map_expected[$].lst = 1'b1;
    id_count   = 0;
    id_dropped = 1'b0;
  endtask

  // Sender: one beat, random idle gaps before it unless gapless.
  // Ready is sampled mid-cycle, so the edge that takes the beat is known.
  task automatic send_id(input logic [63:0] pid, input logic lst, input bit gapless);
    bit taken;
    if (!gapless) begin
      while ($urandom_range(99) < 18) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pid;
    s_axis_tlast  <= lst;
    forever begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
      if (taken) break;
    end
    predict_id(pid, lst);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (map_expected.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_pid(input int mode);
    case (mode)
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(7));
      2: return {$urandom_range(1) ? 32'hffff_ffff : 32'h0, 29'h0, 3'($urandom_range(7))};
      default: return {$urandom_range(1) ? 64'hffff_ffff_ffff_fff0 : 64'h0}
                      | 64'($urandom_range(15));
    endcase
  endfunction

  // Receiver: random stalls, a gapless stretch, and a long hold-off.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (6000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      m_axis_tready <= rx_free_run || ($urandom_range(99) >= 18);
    end
  end

  // Checker: compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    map_beat_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (map_expected.size() == 0) begin
        $display("%0t: unexpected beat pid=%h", $realtime, m_axis_tdata[63:0]);
        errors++;
      end else begin
        e = map_expected.pop_front();
        if (m_axis_tdata[63:0] !== e.pid || m_axis_tdata[69:64] !== e.idx ||
            m_axis_tdata[70] !== e.ovf || m_axis_tdata[71] !== 1'b0 ||
            m_axis_tlast !== e.lst) begin
          $display({"%0t: expected pid=%h idx=%0d ovf=%b last=%b, ",
                    "got pid=%h idx=%0d ovf=%b pad=%b last=%b"},
                   $realtime, e.pid, e.idx, e.ovf, e.lst, m_axis_tdata[63:0],
                   m_axis_tdata[69:64], m_axis_tdata[70], m_axis_tdata[71], m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Directed sets: each row is {pid, last}.  A set of one id has a result
  // readable at a glance; all rows go through the predictor.
  typedef struct {
    logic [63:0] pid;
    logic        lst;
  } id_row_t;

  id_row_t directed_ids[] = '{
    '{64'h0, 1'b1},                     // single id zero
    '{64'hffff_ffff_ffff_ffff, 1'b1},   // single id, all ones
    '{64'h5, 1'b0}, '{64'h5, 1'b0}, '{64'h5, 1'b1},  // all duplicates
    '{64'hffff_ffff_ffff_ffff, 1'b0}, '{64'h0, 1'b0},
    '{64'h8000_0000_0000_0000, 1'b0}, '{64'h7fff_ffff_ffff_ffff, 1'b0},
    '{64'h0, 1'b0}, '{64'h1, 1'b1},    // extremes, unsorted, one repeat
    '{64'haaaa_aaaa_aaaa_aaaa, 1'b0}, '{64'h5555_5555_5555_5555, 1'b1},
    '{64'h3, 1'b0}, '{64'h2, 1'b0}, '{64'h1, 1'b1}   // descending
  };

  initial begin
    int sent;
    int n;
    int mode;
    bit first_set;
    errors = 0;
    id_count = 0;
    id_dropped = 1'b0;
    hold_off = 1'b0;
    rx_free_run = 1'b0;
    first_set = 1'b1;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ids[r]) begin
      send_id(directed_ids[r].pid, directed_ids[r].lst, 1'b0);
      if (r == 0) begin
        // single zero id: one beat, index 0, last, no overflow
        wait_drained();
      end
    end

    // Full set past capacity, marked item dropped too: overflow on every beat.
    // Sent gapless with the receiver held off to back up the block.
    wait_drained();
    hold_off = 1'b1;
    for (int i = 0; i < suim_pkg::MaxIds + 3; i++)
      send_id(64'(suim_pkg::MaxIds - i) ^ {$urandom_range(1), 63'h0},
              i == suim_pkg::MaxIds + 2, 1'b1);
    sent = suim_pkg::MaxIds + 3 + directed_ids.size();

    // Random sets: mostly small, a few near or past capacity.  The first set is
    // offered while the held-off block is still busy.
    while (sent < 230) begin
      if (!first_set && $urandom_range(2) == 0) wait_drained();
      first_set = 1'b0;
      rx_free_run = ($urandom_range(9) == 0);
      if ($urandom_range(9) == 0) n = suim_pkg::MaxIds - 2 + $urandom_range(6);
      else n = $urandom_range(1, 8);
      if (n > 230 - sent) n = 230 - sent;
      mode = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
        send_id(rand_pid(mode), i == n - 1, rx_free_run);
        sent++;
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && map_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== sort_unique_id_map.f =====
rtl/suim_pkg.sv
rtl/suim_ctrl.sv
rtl/suim_dp.sv
rtl/sort_unique_id_map.sv
bench/testbench.sv
